### rtl/core/vfsb_pkg.sv
// shared types and constants for the vector field sink brush
package vfsb_pkg;

	localparam int GRID_COLS = 512;
	localparam int GRID_ROWS = 512;
	localparam int GW        = 13;   // wide enough for grid sizes up to 4096

	// register indexes on the configuration port
	localparam int CFG_IW = 3;
	localparam logic [CFG_IW-1:0] CFG_CENTER_X     = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_CENTER_Y     = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_BRUSH_RADIUS = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_STRENGTH     = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_CELL_SPACING = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_OFFSET_X     = 3'd5;
	localparam logic [CFG_IW-1:0] CFG_OFFSET_Y     = 3'd6;

	// square root: 51-bit radicand, one result bit per stage
	localparam int SQ_NW    = 51;
	localparam int SQ_RW    = 52;
	localparam int SQ_STEPS = 26;
	localparam int DQ_W     = 26;

	// divider: 58-bit dividend, 43-bit divisor, one quotient bit per stage
	localparam int DV_NW = 58;
	localparam int DV_DW = 43;
	localparam int DV_RW = 60;
	localparam int QW    = 18;

	typedef struct packed {
		logic [8:0]         col;
		logic [8:0]         row;
		logic signed [15:0] vec_x;
		logic signed [15:0] vec_y;
	} in_t;

	typedef struct packed {
		logic signed [15:0] new_x;
		logic signed [15:0] new_y;
		logic               touched;
	} out_t;

	typedef struct packed {
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic               act;
		logic               negx;
		logic               negy;
		logic [32:0]        prod_x;
		logic [32:0]        prod_y;
	} sq_side_t;

	typedef struct packed {
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic               act;
		logic               negx;
		logic               negy;
	} dv_side_t;

endpackage

### rtl/core/vfsb_sqrt.sv
// pipelined integer square root, one result bit per stage
module vfsb_sqrt import vfsb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [SQ_NW-1:0] rad,
	input  sq_side_t         side_in,
	output logic             out_valid,
	output logic [DQ_W-1:0]  root,
	output sq_side_t         side_out
);

	logic             v_s    [0:SQ_STEPS-1];
	logic [SQ_NW-1:0] rem_s  [0:SQ_STEPS-1];
	logic [SQ_RW-1:0] root_s [0:SQ_STEPS-1];
	sq_side_t         side_s [0:SQ_STEPS-1];

	logic             v_i    [0:SQ_STEPS-1];
	logic [SQ_NW-1:0] rem_i  [0:SQ_STEPS-1];
	logic [SQ_RW-1:0] root_i [0:SQ_STEPS-1];
	sq_side_t         side_i [0:SQ_STEPS-1];
	logic [SQ_RW-1:0] trial  [0:SQ_STEPS-1];
	logic [SQ_RW-1:0] bitk   [0:SQ_STEPS-1];
	logic             ge     [0:SQ_STEPS-1];
	logic [SQ_NW-1:0] rem_n  [0:SQ_STEPS-1];
	logic [SQ_RW-1:0] root_n [0:SQ_STEPS-1];

	always_comb begin
		v_i[0]    = in_valid;
		rem_i[0]  = rad;
		root_i[0] = '0;
		side_i[0] = side_in;
		for (int k = 1; k < SQ_STEPS; k++) begin
			v_i[k]    = v_s[k-1];
			rem_i[k]  = rem_s[k-1];
			root_i[k] = root_s[k-1];
			side_i[k] = side_s[k-1];
		end
		for (int k = 0; k < SQ_STEPS; k++) begin
			// test bit weight falls by a factor of four each stage
			bitk[k]   = SQ_RW'(1) << (2 * (SQ_STEPS - 1 - k));
			trial[k]  = root_i[k] + bitk[k];
			ge[k]     = {1'b0, rem_i[k]} >= trial[k];
			rem_n[k]  = ge[k] ? rem_i[k] - trial[k][SQ_NW-1:0] : rem_i[k];
			root_n[k] = ge[k] ? (root_i[k] >> 1) + bitk[k] : root_i[k] >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SQ_STEPS; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			for (int k = 0; k < SQ_STEPS; k++) v_s[k] <= v_i[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SQ_STEPS; k++) begin
				rem_s[k]  <= rem_n[k];
				root_s[k] <= root_n[k];
				side_s[k] <= side_i[k];
			end
		end
	end

	assign out_valid = v_s[SQ_STEPS-1];
	assign root      = root_s[SQ_STEPS-1][DQ_W-1:0];
	assign side_out  = side_s[SQ_STEPS-1];

endmodule

### rtl/core/vfsb_div.sv
// pipelined two-lane restoring divider, one quotient bit per stage
module vfsb_div import vfsb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [DV_NW-1:0] num_x,
	input  logic [DV_NW-1:0] num_y,
	input  logic [DV_DW-1:0] den,
	input  dv_side_t         side_in,
	output logic             out_valid,
	output logic [QW-1:0]    q_x,
	output logic [QW-1:0]    q_y,
	output dv_side_t         side_out
);

	logic             v_s    [0:QW-1];
	logic [DV_RW-1:0] rx_s   [0:QW-1];
	logic [DV_RW-1:0] ry_s   [0:QW-1];
	logic [DV_DW-1:0] d_s    [0:QW-1];
	logic [QW-1:0]    qx_s   [0:QW-1];
	logic [QW-1:0]    qy_s   [0:QW-1];
	dv_side_t         side_s [0:QW-1];

	logic             v_i    [0:QW-1];
	logic [DV_RW-1:0] rx_i   [0:QW-1];
	logic [DV_RW-1:0] ry_i   [0:QW-1];
	logic [DV_DW-1:0] d_i    [0:QW-1];
	logic [QW-1:0]    qx_i   [0:QW-1];
	logic [QW-1:0]    qy_i   [0:QW-1];
	dv_side_t         side_i [0:QW-1];
	logic [DV_RW-1:0] sh     [0:QW-1];
	logic             gex    [0:QW-1];
	logic             gey    [0:QW-1];

	always_comb begin
		v_i[0]    = in_valid;
		rx_i[0]   = DV_RW'(num_x);
		ry_i[0]   = DV_RW'(num_y);
		d_i[0]    = den;
		qx_i[0]   = '0;
		qy_i[0]   = '0;
		side_i[0] = side_in;
		for (int k = 1; k < QW; k++) begin
			v_i[k]    = v_s[k-1];
			rx_i[k]   = rx_s[k-1];
			ry_i[k]   = ry_s[k-1];
			d_i[k]    = d_s[k-1];
			qx_i[k]   = qx_s[k-1];
			qy_i[k]   = qy_s[k-1];
			side_i[k] = side_s[k-1];
		end
		for (int k = 0; k < QW; k++) begin
			sh[k]  = DV_RW'(d_i[k]) << (QW - 1 - k);
			gex[k] = rx_i[k] >= sh[k];
			gey[k] = ry_i[k] >= sh[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QW; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			for (int k = 0; k < QW; k++) v_s[k] <= v_i[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				rx_s[k]   <= gex[k] ? rx_i[k] - sh[k] : rx_i[k];
				ry_s[k]   <= gey[k] ? ry_i[k] - sh[k] : ry_i[k];
				qx_s[k]   <= {qx_i[k][QW-2:0], gex[k]};
				qy_s[k]   <= {qy_i[k][QW-2:0], gey[k]};
				d_s[k]    <= d_i[k];
				side_s[k] <= side_i[k];
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign q_x       = qx_s[QW-1];
	assign q_y       = qy_s[QW-1];
	assign side_out  = side_s[QW-1];

endmodule

### rtl/core/vector_field_sink_brush_core.sv
// top level of the radial sink/source brush over a grid of vectors
// usage:
//   requests enter on in_valid/in_ready/in_data: one grid cell (col, row)
//   and its Q4.12 vector; results leave on out_valid/out_ready/out_data
//   with the updated vector and a touched flag, one result per request,
//   in request order. registers are written through cfg_we/cfg_idx/
//   cfg_wdata; the user must write them only while no request is in
//   flight, which the block does not enforce; unknown indexes are ignored.
// timing:
//   one request per cycle sustained while out_ready lets the pipeline
//   advance; each request passes through 51 register stages: 3 front
//   stages, 26 square-root stages, 3 stages that form the dividend,
//   18 divider stages and the output register.
// stall:
//   the whole pipeline advances together; while a result sits unread in the
//   output register, in_ready is low and every stage holds.
// reset:
//   arst_n empties the pipeline and loads register defaults: all zero
//   except cell spacing 8.
module vector_field_sink_brush_core import vfsb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_t               in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_t              out_data,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_idx,
	input  logic [15:0]       cfg_wdata
);

	logic signed [15:0] center_x_q, center_y_q, strength_q;
	logic [15:0]        radius_q;
	logic [6:0]         spacing_q;
	logic signed [11:0] offset_x_q, offset_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= '0;
			strength_q <= '0;
			spacing_q  <= 7'd8;
			offset_x_q <= '0;
			offset_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_CENTER_X:     center_x_q <= cfg_wdata;
				CFG_CENTER_Y:     center_y_q <= cfg_wdata;
				CFG_BRUSH_RADIUS: radius_q   <= cfg_wdata;
				CFG_STRENGTH:     strength_q <= cfg_wdata;
				CFG_CELL_SPACING: spacing_q  <= cfg_wdata[6:0];
				CFG_OFFSET_X:     offset_x_q <= cfg_wdata[11:0];
				CFG_OFFSET_Y:     offset_y_q <= cfg_wdata[11:0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: pixel offset from the brush centre
	logic               v_s1, grid_s1;
	logic signed [17:0] dx_s1, dy_s1;
	logic signed [15:0] vx_s1, vy_s1;
	logic [15:0]        posx, posy;
	logic               in_grid;

	always_comb begin
		posx    = 16'(in_data.col) * 16'(spacing_q);
		posy    = 16'(in_data.row) * 16'(spacing_q);
		in_grid = ({4'b0, in_data.col} < GW'(GRID_COLS)) &&
		          ({4'b0, in_data.row} < GW'(GRID_ROWS));
	end

	// stage 2: magnitudes and squared distance
	logic               v_s2, grid_s2, dxn_s2, dyn_s2;
	logic [16:0]        ax_s2, ay_s2;
	logic [34:0]        d2_s2;
	logic signed [15:0] vx_s2, vy_s2;
	logic [16:0]        ax_c, ay_c;

	always_comb begin
		ax_c = dx_s1[17] ? 17'(-dx_s1) : 17'(dx_s1);
		ay_c = dy_s1[17] ? 17'(-dy_s1) : 17'(dy_s1);
	end

	// stage 3: inside test and strength products
	logic        v_s3;
	logic [34:0] d2_s3;
	sq_side_t    side_s3;
	logic [31:0] rr;
	logic [15:0] smag;
	logic        in_brush;

	always_comb begin
		rr       = 32'(radius_q) * 32'(radius_q);
		in_brush = (radius_q == '0) || (d2_s2 <= 35'(rr));
		smag     = strength_q[15] ? 16'(-strength_q) : 16'(strength_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grid_s1 <= in_grid;
			dx_s1   <= $signed({2'b00, posx}) + 18'(offset_x_q) - 18'(center_x_q);
			dy_s1   <= $signed({2'b00, posy}) + 18'(offset_y_q) - 18'(center_y_q);
			vx_s1   <= in_data.vec_x;
			vy_s1   <= in_data.vec_y;

			grid_s2 <= grid_s1;
			dxn_s2  <= dx_s1[17];
			dyn_s2  <= dy_s1[17];
			ax_s2   <= ax_c;
			ay_s2   <= ay_c;
			d2_s2   <= 35'(34'(ax_c) * 34'(ax_c)) + 35'(34'(ay_c) * 34'(ay_c));
			vx_s2   <= vx_s1;
			vy_s2   <= vy_s1;

			d2_s3          <= d2_s2;
			side_s3.vx     <= vx_s2;
			side_s3.vy     <= vy_s2;
			side_s3.act    <= grid_s2 && in_brush && (d2_s2 != '0);
			side_s3.negx   <= strength_q[15] ^ dxn_s2;
			side_s3.negy   <= strength_q[15] ^ dyn_s2;
			side_s3.prod_x <= 33'(smag) * 33'(ax_s2);
			side_s3.prod_y <= 33'(smag) * 33'(ay_s2);
		end
	end

	// distance in Q.8 pixels
	logic            v_sq;
	logic [DQ_W-1:0] dq;
	sq_side_t        side_sq;

	vfsb_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.rad      ({d2_s3, 16'b0}),
		.side_in  (side_s3),
		.out_valid(v_sq),
		.root     (dq),
		.side_out (side_sq)
	);

	// stage 4: falloff and denominator
	logic        v_s4;
	logic [23:0] fall_s4;
	logic [41:0] den_s4;
	sq_side_t    side_s4;
	logic [25:0] rq;

	assign rq = {2'b00, radius_q, 8'b0};

	// stage 5: numerators
	logic        v_s5;
	logic [56:0] nx_s5, ny_s5;
	logic [41:0] den_s5;
	dv_side_t    side_s5;

	// stage 6: rounding offset folded into the dividend
	logic             v_s6;
	logic [DV_NW-1:0] nx_s6, ny_s6;
	logic [DV_DW-1:0] den_s6;
	dv_side_t         side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_sq;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_sq;
			if (radius_q == '0) begin
				fall_s4 <= 24'd256;
				den_s4  <= 42'(dq);
			end else begin
				fall_s4 <= (rq > dq) ? 24'(rq - dq) : '0;
				den_s4  <= 42'(dq) * 42'(radius_q);
			end

			nx_s5        <= 57'(side_s4.prod_x) * 57'(fall_s4);
			ny_s5        <= 57'(side_s4.prod_y) * 57'(fall_s4);
			den_s5       <= den_s4;
			side_s5.vx   <= side_s4.vx;
			side_s5.vy   <= side_s4.vy;
			side_s5.act  <= side_s4.act;
			side_s5.negx <= side_s4.negx;
			side_s5.negy <= side_s4.negy;

			nx_s6   <= {nx_s5, 1'b0} + DV_NW'(den_s5);
			ny_s6   <= {ny_s5, 1'b0} + DV_NW'(den_s5);
			den_s6  <= {den_s5, 1'b0};
			side_s6 <= side_s5;
		end
	end

	logic          v_dv;
	logic [QW-1:0] qx, qy;
	dv_side_t      side_dv;

	vfsb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s6),
		.num_x    (nx_s6),
		.num_y    (ny_s6),
		.den      (den_s6),
		.side_in  (side_s6),
		.out_valid(v_dv),
		.q_x      (qx),
		.q_y      (qy),
		.side_out (side_dv)
	);

	// output: signed push, saturating add
	logic signed [19:0] sum_x, sum_y;
	logic signed [15:0] sat_x, sat_y;

	always_comb begin
		sum_x = 20'(side_dv.vx) +
		        (side_dv.negx ? -$signed({2'b00, qx}) : $signed({2'b00, qx}));
		sum_y = 20'(side_dv.vy) +
		        (side_dv.negy ? -$signed({2'b00, qy}) : $signed({2'b00, qy}));
		if (sum_x > 20'sd32767)       sat_x = 16'sh7fff;
		else if (sum_x < -20'sd32768) sat_x = 16'sh8000;
		else                          sat_x = 16'(sum_x);
		if (sum_y > 20'sd32767)       sat_y = 16'sh7fff;
		else if (sum_y < -20'sd32768) sat_y = 16'sh8000;
		else                          sat_y = 16'(sum_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_dv;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.new_x   <= side_dv.act ? sat_x : side_dv.vx;
			out_data.new_y   <= side_dv.act ? sat_y : side_dv.vy;
			out_data.touched <= side_dv.act;
		end
	end

endmodule
